FILE: hw/rtl/packet_pixel_radial_gain_overlay_defines.svh
// Assertion helpers shared by the RTL files.
// Each macro expects clk and arst_n in scope.
`ifndef PACKET_PIXEL_RADIAL_GAIN_OVERLAY_DEFINES_SVH
`define PACKET_PIXEL_RADIAL_GAIN_OVERLAY_DEFINES_SVH

// Same-cycle implication.
`define PPGO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PPGO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ppgo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppgo_pkg
// Types and constants of the packet pixel gain/overlay block.
// ----------------------------------------------------------------------------
package ppgo_pkg;

	localparam int unsigned LANES      = 4;
	localparam int unsigned PIX_W      = 16;
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned GAIN_SHIFT = 7;
	localparam int unsigned GAIN_W     = 6;

	localparam logic [PIX_W-1:0] PIX_WHITE = 16'hFFFF;
	localparam logic [PIX_W-1:0] PIX_BLACK = 16'h0000;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_CORRECT = 2'd0,
		CFG_OVERLAY = 2'd1,
		CFG_TOGGLE  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic correct;
		logic overlay;
		logic toggle;
	} cfg_t;

	// per-word context from the packet tracker
	typedef struct packed {
		logic               payload;
		logic [COORD_W-1:0] base_x;
		logic [COORD_W-1:0] y;
		logic               p;
	} ctx_t;

endpackage

FILE: hw/rtl/ppgo_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppgo_lane
// One pixel lane: radial gain with saturation, then checkerboard overlay.
// ----------------------------------------------------------------------------
module ppgo_lane
	import ppgo_pkg::*;
#(
	parameter int unsigned IMAGE_WIDTH  = 2048,
	parameter int unsigned IMAGE_HEIGHT = 1024,
	parameter int unsigned TILE_SHIFT   = 5
) (
	input  cfg_t               cfg,
	input  logic [PIX_W-1:0]   pix,
	input  logic [COORD_W-1:0] x,
	input  logic [COORD_W-1:0] y,
	input  logic               p,
	output logic [PIX_W-1:0]   res
);

	localparam logic [COORD_W-1:0] CX = COORD_W'(IMAGE_WIDTH / 2);
	localparam logic [COORD_W-1:0] CY = COORD_W'(IMAGE_HEIGHT / 2);

	logic [COORD_W-1:0] dx, dy;
	logic [COORD_W:0]   dsum;
	logic [GAIN_W-1:0]  gain;
	logic [PIX_W:0]     gsum;
	logic [PIX_W-1:0]   corr;
	logic               cell_odd;

	always_comb begin
		dx   = (x >= CX) ? (x - CX) : (CX - x);
		dy   = (y >= CY) ? (y - CY) : (CY - y);
		dsum = {1'b0, dx} + {1'b0, dy};
		gain = dsum[GAIN_SHIFT +: GAIN_W];
		gsum = {1'b0, pix} + {{(PIX_W+1-GAIN_W){1'b0}}, gain};
		if (cfg.correct)
			corr = gsum[PIX_W] ? PIX_WHITE : gsum[PIX_W-1:0];
		else
			corr = pix;
		// parity of the tile sum picks the forced cells
		cell_odd = x[TILE_SHIFT] ^ y[TILE_SHIFT] ^ p;
		if (cfg.overlay && !cell_odd)
			res = p ? PIX_WHITE : PIX_BLACK;
		else
			res = corr;
	end

endmodule

FILE: hw/rtl/ppgo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppgo_ctrl
// Packet tracker: header decode, word position and frame phase.
// ----------------------------------------------------------------------------
`include "packet_pixel_radial_gain_overlay_defines.svh"
module ppgo_ctrl
	import ppgo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        acc,
	input  logic [63:0] data,
	input  logic        last,
	output ctx_t        ctx
);

	logic               inside_q;
	logic [5:0]         word_q;
	logic [COORD_W-1:0] line_q;
	logic [COORD_W-1:0] prev_q;
	logic [3:0]         pkt_q;
	logic               phase_q;
	logic               seen_q;

	logic [COORD_W-1:0] hdr_line;
	logic [3:0]         hdr_pkt;

	assign hdr_line = data[23:12];
	assign hdr_pkt  = data[11:8];

	always_comb begin
		ctx.payload = inside_q;
		ctx.base_x  = {1'b0, pkt_q, 7'd0} + {4'd0, word_q, 2'd0};
		ctx.y       = line_q;
		ctx.p       = cfg.toggle & phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			word_q   <= '0;
			line_q   <= '0;
			prev_q   <= '0;
			pkt_q    <= '0;
			phase_q  <= 1'b0;
			seen_q   <= 1'b0;
		end else if (acc) begin
			if (!inside_q) begin
				if (hdr_pkt == 4'd0) begin
					// new frame when the line number goes backwards
					if (seen_q && hdr_line < prev_q && cfg.toggle)
						phase_q <= ~phase_q;
					prev_q <= hdr_line;
					seen_q <= 1'b1;
				end
				line_q   <= hdr_line;
				pkt_q    <= hdr_pkt;
				word_q   <= '0;
				inside_q <= ~last;
			end else begin
				word_q <= last ? 6'd0 : word_q + 6'd1;
				if (last)
					inside_q <= 1'b0;
			end
		end
	end

	`PPGO_ASSERT_NEXT(a_last_ends_pkt, acc && last, !inside_q && word_q == 6'd0, "last did not close packet")
	`PPGO_ASSERT_NEXT(a_word_step, acc && inside_q && !last, word_q == $past(word_q) + 6'd1, "word index did not advance")
	`PPGO_ASSERT_NOW(a_phase_gated, !cfg.toggle, !ctx.p, "phase used while toggling off")

endmodule

FILE: hw/rtl/packet_pixel_radial_gain_overlay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_pixel_radial_gain_overlay
// Per-packet pixel gain and checkerboard overlay on a 64-bit pixel stream.
// ----------------------------------------------------------------------------
// Pipeline: stage 1 registers the word with its packet context, stage 2 the merged lanes.
// Throughput: one word per cycle; four pixel lanes run in parallel per word.
// The pipeline stalls as a whole only while the output register is held.
// Reset (arst_n low): config cleared, packet tracker expects a header,
// frame phase zero, pipeline empty.
`include "packet_pixel_radial_gain_overlay_defines.svh"
module packet_pixel_radial_gain_overlay
	import ppgo_pkg::*;
#(
	parameter int unsigned IMAGE_WIDTH  = 2048,
	parameter int unsigned IMAGE_HEIGHT = 1024,
	parameter int unsigned TILE_SHIFT   = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // in_data
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_data
	output logic        m_axis_tlast
);

	cfg_t        cfg_q;
	ctx_t        ctx;
	logic        adv;
	logic        acc;

	logic        valid_s1;
	logic [63:0] data_s1;
	logic        last_s1;
	ctx_t        ctx_s1;

	logic        valid_s2;
	logic [63:0] data_s2;
	logic        last_s2;

	logic [63:0] lane_res;

	assign adv           = !valid_s2 || m_axis_tready;
	assign s_axis_tready = adv;
	assign acc           = s_axis_tvalid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_CORRECT: cfg_q.correct <= cfg_wdata;
				CFG_OVERLAY: cfg_q.overlay <= cfg_wdata;
				CFG_TOGGLE:  cfg_q.toggle  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ppgo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.acc    (acc),
		.data   (s_axis_tdata),
		.last   (s_axis_tlast),
		.ctx    (ctx)
	);

	// stage 1: word plus its packet context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
			ctx_s1  <= ctx;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic [COORD_W-1:0] lx;
		assign lx = {ctx_s1.base_x[COORD_W-1:2], 2'(i)};
		ppgo_lane #(
			.IMAGE_WIDTH  (IMAGE_WIDTH),
			.IMAGE_HEIGHT (IMAGE_HEIGHT),
			.TILE_SHIFT   (TILE_SHIFT)
		) u_lane (
			.cfg (cfg_q),
			.pix (data_s1[i*PIX_W +: PIX_W]),
			.x   (lx),
			.y   (ctx_s1.y),
			.p   (ctx_s1.p),
			.res (lane_res[i*PIX_W +: PIX_W])
		);
	end

	// stage 2: merge lanes, headers pass untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			data_s2 <= ctx_s1.payload ? lane_res : data_s1;
			last_s2 <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tlast  = last_s2;

	`PPGO_ASSERT_NEXT(a_hdr_pass, adv && valid_s1 && !ctx_s1.payload, data_s2 == $past(data_s1), "header altered")
	`PPGO_ASSERT_NEXT(a_plain_pass, adv && valid_s1 && !cfg_q.correct && !cfg_q.overlay, data_s2 == $past(data_s1), "payload altered with both enables off")
	`PPGO_ASSERT_NEXT(a_last_follow, adv && valid_s1, valid_s2 && last_s2 == $past(last_s1), "last flag lost")

endmodule
